[rtl/mdf_pkg.sv]
// ----------------------------------------------------------------------------
// mdf_pkg - shared definitions for the message duplicate filter
// Field widths, default store depth and the sequencer state type.
// ----------------------------------------------------------------------------
package mdf_pkg;

	localparam int unsigned MAC_W = 48;
	localparam int unsigned UID_W = 64;
	localparam int unsigned KEY_W = MAC_W + UID_W;

	localparam int unsigned DEFAULT_CACHE_ENTRIES = 32;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_WRITE,
		ST_DONE
	} state_t;

endpackage

[rtl/mdf_if.sv]
// ----------------------------------------------------------------------------
// mdf_if - request and response channels of the duplicate filter
// Valid/ready channels; a request moves on a clock edge with both high.
// ----------------------------------------------------------------------------
interface mdf_req_if;
	logic                      valid;
	logic                      ready;
	logic [mdf_pkg::MAC_W-1:0] origin_mac;
	logic [mdf_pkg::UID_W-1:0] message_uid;

	modport source (output valid, output origin_mac, output message_uid, input ready);
	modport sink   (input valid, input origin_mac, input message_uid, output ready);
endinterface

interface mdf_rsp_if;
	logic valid;
	logic ready;
	logic is_duplicate;

	modport source (output valid, output is_duplicate, input ready);
	modport sink   (input valid, input is_duplicate, output ready);
endinterface

[rtl/message_duplicate_filter_top.sv]
// ----------------------------------------------------------------------------
// message_duplicate_filter_top - seen-message cache with FIFO replacement
// Flags (MAC, identifier) pairs already held in a ring of recent pairs.
// ----------------------------------------------------------------------------
// Usage:
//   req carries origin_mac and message_uid; rsp returns is_duplicate, one
//   response per request, in order.
//   Each request walks the whole store through one read port and a single
//   112-bit comparator, one entry per cycle. The last entry is compared in
//   the drain state; a new pair then passes the write state, while a
//   duplicate skips the write and goes straight to the final state. The
//   next request is taken once the block is back in idle.
//   A new pair is written at the ring head and the head advances with wrap;
//   a duplicate leaves the store untouched.
//   Reset clears the per-entry valid bits and the head pointer at once; an
//   entry not yet written reads as all zeros, so the all-zero pair counts as
//   a duplicate until every entry has been overwritten. No clearing pass.
//   rsp sits in an output register: a stalled receiver holds the response,
//   a new request may still be accepted and scanned, and it waits in the
//   final state until the output register is free.
// ----------------------------------------------------------------------------
module message_duplicate_filter_top #(
	parameter int unsigned CACHE_ENTRIES = mdf_pkg::DEFAULT_CACHE_ENTRIES
) (
	input  logic       clk,
	input  logic       arst_n,
	mdf_req_if.sink    req,
	mdf_rsp_if.source  rsp
);

	localparam int unsigned AW = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
	localparam logic [AW-1:0] LAST_IDX = AW'(CACHE_ENTRIES - 1);

	mdf_pkg::state_t state_q, state_d;

	logic [mdf_pkg::KEY_W-1:0] key_q;
	logic [AW-1:0]             scan_addr_q;
	logic [AW-1:0]             ptr_q;
	logic [CACHE_ENTRIES-1:0]  valid_q;

	logic [mdf_pkg::KEY_W-1:0] mem [CACHE_ENTRIES];
	logic [mdf_pkg::KEY_W-1:0] rdata_s1;
	logic                      rvalid_s1;
	logic                      cmp_en_s1;

	logic                      matched_q;
	logic                      rsp_valid_q;
	logic                      rsp_dup_q;

	logic                      hit_s1;
	logic [mdf_pkg::KEY_W-1:0] entry_key;

	logic accept;
	logic mem_we;
	logic load_rsp;

	assign accept = req.valid && req.ready;

	// unwritten entries read as zero
	assign entry_key = rvalid_s1 ? rdata_s1 : '0;
	assign hit_s1    = cmp_en_s1 && (entry_key == key_q);

	always_comb begin
		state_d   = state_q;
		req.ready = 1'b0;
		mem_we    = 1'b0;
		load_rsp  = 1'b0;
		case (state_q)
			mdf_pkg::ST_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					state_d = mdf_pkg::ST_SCAN;
				end
			end
			mdf_pkg::ST_SCAN: begin
				if (scan_addr_q == LAST_IDX) begin
					state_d = mdf_pkg::ST_DRAIN;
				end
			end
			mdf_pkg::ST_DRAIN: begin
				// last entry is compared here
				state_d = (matched_q || hit_s1) ? mdf_pkg::ST_DONE : mdf_pkg::ST_WRITE;
			end
			mdf_pkg::ST_WRITE: begin
				mem_we  = 1'b1;
				state_d = mdf_pkg::ST_DONE;
			end
			mdf_pkg::ST_DONE: begin
				if (!rsp_valid_q || rsp.ready) begin
					load_rsp = 1'b1;
					state_d  = mdf_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = mdf_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mdf_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_addr_q <= '0;
			ptr_q       <= '0;
			valid_q     <= '0;
			cmp_en_s1   <= 1'b0;
			matched_q   <= 1'b0;
			rsp_valid_q <= 1'b0;
			rsp_dup_q   <= 1'b0;
		end else begin
			cmp_en_s1 <= (state_q == mdf_pkg::ST_SCAN);

			if (state_q == mdf_pkg::ST_SCAN) begin
				scan_addr_q <= (scan_addr_q == LAST_IDX) ? '0 : scan_addr_q + 1'b1;
			end

			if (accept) begin
				matched_q <= 1'b0;
			end else if (hit_s1) begin
				matched_q <= 1'b1;
			end

			if (mem_we) begin
				valid_q[ptr_q] <= 1'b1;
				ptr_q          <= (ptr_q == LAST_IDX) ? '0 : ptr_q + 1'b1;
			end

			if (load_rsp) begin
				rsp_valid_q <= 1'b1;
				rsp_dup_q   <= matched_q;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			key_q <= {req.origin_mac, req.message_uid};
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[ptr_q] <= key_q;
		end
		rdata_s1  <= mem[scan_addr_q];
		rvalid_s1 <= valid_q[scan_addr_q];
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.is_duplicate = rsp_dup_q;

	// Assertions

	a_scan_idle_zero : assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mdf_pkg::ST_IDLE) |-> (scan_addr_q == '0))
		else $error("scan address not rewound in idle");

	a_dup_no_write : assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mdf_pkg::ST_DRAIN && (matched_q || hit_s1)) |=>
		(state_q == mdf_pkg::ST_DONE && $stable(ptr_q)))
		else $error("duplicate request reached the write step");

	a_rsp_from_done : assert property (@(posedge clk) disable iff (!arst_n)
		(load_rsp) |-> (state_q == mdf_pkg::ST_DONE))
		else $error("response loaded outside the final state");

	a_head_advance : assert property (@(posedge clk) disable iff (!arst_n)
		(mem_we && CACHE_ENTRIES > 1) |=> (ptr_q != $past(ptr_q)))
		else $error("ring head did not advance after a write");

endmodule
